// ----- hdl/drp_pkg.sv -----
// Shared types and constants for the disparity reprojection pipeline.
package drp_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FOCAL      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_W_PER_DISP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_W_OFFSET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_MIN      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Z_MAX      = 3'd6;

	localparam int OFF_W   = 17;
	localparam int FOCAL_W = 18;
	localparam int GAIN_W  = 32;
	localparam int ZLIM_W  = 31;

	localparam logic signed [OFF_W-1:0]  RST_OFFSET_X   = 17'sd0;
	localparam logic signed [OFF_W-1:0]  RST_OFFSET_Y   = 17'sd0;
	localparam logic [FOCAL_W-1:0]       RST_FOCAL      = 18'd16384;
	localparam logic signed [GAIN_W-1:0] RST_W_PER_DISP = 32'sd655360;
	localparam logic signed [GAIN_W-1:0] RST_W_OFFSET   = 32'sd0;
	localparam logic [ZLIM_W-1:0]        RST_Z_MIN      = 31'd13107;   // 0.2
	localparam logic [ZLIM_W-1:0]        RST_Z_MAX      = 31'd131072;  // 2.0

	localparam int COL_W   = 12;
	localparam int DISP_W  = 16;
	localparam int NUM_W   = 18;   // signed numerator, 1/16 pixel
	localparam int NMAG_W  = 18;   // numerator magnitude
	localparam int PROD_W  = 48;
	localparam int WS_W    = 49;   // exact W, Q.20
	localparam int WMAG_W  = 48;   // |W|
	localparam int Q_W     = 32;
	localparam int LANES   = 3;
	localparam int LANE_X  = 0;
	localparam int LANE_Y  = 1;
	localparam int LANE_Z  = 2;
	localparam int DIV_STEPS = 32;

	localparam logic [Q_W-1:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

	typedef struct packed {
		logic             zero;
		logic [LANES-1:0] neg;
		logic [Q_W-1:0]   hw;
	} drp_side_t;

	typedef struct packed {
		logic [LANES-1:0]             ovf;
		logic [LANES-1:0][WMAG_W-1:0] rem;
		logic [WMAG_W-1:0]            dvs;
		drp_side_t                    side;
	} drp_div_in_t;

	typedef struct packed {
		logic [LANES-1:0]          ovf;
		logic [LANES-1:0][Q_W-1:0] mag;
		drp_side_t                 side;
	} drp_div_out_t;

endpackage

// ----- hdl/drp_ifs.sv -----
// Stream channel interfaces: pixel input and 3D point output.
interface drp_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] col;
	logic [11:0] row;
	logic signed [15:0] disparity;
	modport source(output valid, col, row, disparity, input ready);
	modport sink(input valid, col, row, disparity, output ready);
endinterface

interface drp_out_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [31:0] point_z;
	logic signed [31:0] homog_w;
	logic        keep;
	modport source(output valid, point_x, point_y, point_z, homog_w, keep, input ready);
	modport sink(input valid, point_x, point_y, point_z, homog_w, keep, output ready);
endinterface

// ----- hdl/disparity_reproject_to_3d_top.sv -----
// Top level: config registers, pipeline control and stage instances.
// Takes one pixel per clock and returns one point per pixel, in order. The
// pipeline is the 32-stage restoring divider (one quotient bit per stage, X, Y
// and Z lanes in parallel sharing one divisor) behind four front stages
// (product, W sum, magnitudes, overflow check) and ahead of one output register.
// When the output is not taken the whole pipeline holds and the input is not
// ready. Registers may be written only while no pixel is in flight.
module disparity_reproject_to_3d_top import drp_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	drp_in_if.sink                in_ch,
	drp_out_if.source             out_ch
);

	logic signed [OFF_W-1:0]  off_x_q, off_y_q;
	logic [FOCAL_W-1:0]       focal_q;
	logic signed [GAIN_W-1:0] gain_q, w_off_q;
	logic [ZLIM_W-1:0]        z_min_q, z_max_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_x_q <= RST_OFFSET_X;
			off_y_q <= RST_OFFSET_Y;
			focal_q <= RST_FOCAL;
			gain_q  <= RST_W_PER_DISP;
			w_off_q <= RST_W_OFFSET;
			z_min_q <= RST_Z_MIN;
			z_max_q <= RST_Z_MAX;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_OFFSET_X:   off_x_q <= cfg_data[OFF_W-1:0];
				REG_OFFSET_Y:   off_y_q <= cfg_data[OFF_W-1:0];
				REG_FOCAL:      focal_q <= cfg_data[FOCAL_W-1:0];
				REG_W_PER_DISP: gain_q  <= cfg_data[GAIN_W-1:0];
				REG_W_OFFSET:   w_off_q <= cfg_data[GAIN_W-1:0];
				REG_Z_MIN:      z_min_q <= cfg_data[ZLIM_W-1:0];
				REG_Z_MAX:      z_max_q <= cfg_data[ZLIM_W-1:0];
				default: ;
			endcase
		end
	end

	logic         en;
	logic         fr_valid, dv_valid;
	drp_div_in_t  fr_data;
	drp_div_out_t dv_data;

	assign en          = !out_ch.valid || out_ch.ready;
	assign in_ch.ready = en;

	drp_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (in_ch.valid),
		.col       (in_ch.col),
		.row       (in_ch.row),
		.disparity (in_ch.disparity),
		.off_x     (off_x_q),
		.off_y     (off_y_q),
		.focal     (focal_q),
		.gain      (gain_q),
		.w_off     (w_off_q),
		.out_valid (fr_valid),
		.out_data  (fr_data)
	);

	drp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_data   (fr_data),
		.out_valid (dv_valid),
		.out_data  (dv_data)
	);

	logic [Q_W-1:0] px, py, pz, hw;

	drp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (dv_valid),
		.in_data   (dv_data),
		.z_min     (z_min_q),
		.z_max     (z_max_q),
		.out_valid (out_ch.valid),
		.point_x   (px),
		.point_y   (py),
		.point_z   (pz),
		.homog_w   (hw),
		.keep      (out_ch.keep)
	);

	assign out_ch.point_x = px;
	assign out_ch.point_y = py;
	assign out_ch.point_z = pz;
	assign out_ch.homog_w = hw;

	a_keep_window: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.keep |->
			pz >= Q_W'(z_min_q) && pz < Q_W'(z_max_q))
		else $error("kept point outside depth window");

endmodule

// ----- hdl/drp_front.sv -----
// Front stages: numerators, W product and sum, magnitudes, overflow check.
module drp_front import drp_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  logic                     in_valid,
	input  logic [COL_W-1:0]         col,
	input  logic [COL_W-1:0]         row,
	input  logic signed [DISP_W-1:0] disparity,
	input  logic signed [OFF_W-1:0]  off_x,
	input  logic signed [OFF_W-1:0]  off_y,
	input  logic [FOCAL_W-1:0]       focal,
	input  logic signed [GAIN_W-1:0] gain,
	input  logic signed [GAIN_W-1:0] w_off,
	output logic                     out_valid,
	output drp_div_in_t              out_data
);

	localparam int CB = (COORD_BITS < COL_W) ? COORD_BITS : COL_W;

	logic [COL_W-1:0] col_eff, row_eff;
	assign col_eff = COL_W'(col[CB-1:0]);
	assign row_eff = COL_W'(row[CB-1:0]);

	logic v_s1, v_s2, v_s3, v_s4;

	logic signed [NUM_W-1:0]  numx_s1, numy_s1;
	logic signed [PROD_W-1:0] prod_s1;

	logic signed [WS_W-1:0]   w_s2;
	logic [LANES-1:0][NMAG_W-1:0] nmag_s2, nmag_s3;
	logic [LANES-1:0]         nneg_s2;

	logic [WMAG_W-1:0]        wmag_s3;
	drp_side_t                side_s3;
	drp_div_in_t              div_s4;

	logic signed [WS_W-5:0]   w_sh;
	logic [Q_W-1:0]           hw_sat;
	logic                     w_neg;

	assign w_sh  = (WS_W-4)'(w_s2 >>> 4);
	assign w_neg = w_s2[WS_W-1];

	// floor(W/16), clamped to 32 bits
	always_comb begin
		if (!((&w_sh[WS_W-5:Q_W-1]) || ~(|w_sh[WS_W-5:Q_W-1]))) begin
			hw_sat = w_neg ? Q_MIN : Q_MAX;
		end else begin
			hw_sat = w_sh[Q_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			numx_s1 <= $signed({2'b00, col_eff, 4'b0000}) + NUM_W'(off_x);
			numy_s1 <= $signed({2'b00, row_eff, 4'b0000}) + NUM_W'(off_y);
			prod_s1 <= PROD_W'(gain) * PROD_W'(disparity);

			w_s2 <= WS_W'(prod_s1) + (WS_W'(w_off) <<< 4);
			nneg_s2[LANE_X] <= numx_s1[NUM_W-1];
			nneg_s2[LANE_Y] <= numy_s1[NUM_W-1];
			nneg_s2[LANE_Z] <= 1'b0;
			nmag_s2[LANE_X] <= numx_s1[NUM_W-1] ? NMAG_W'(-numx_s1) : NMAG_W'(numx_s1);
			nmag_s2[LANE_Y] <= numy_s1[NUM_W-1] ? NMAG_W'(-numy_s1) : NMAG_W'(numy_s1);
			nmag_s2[LANE_Z] <= NMAG_W'(focal);

			wmag_s3      <= w_neg ? WMAG_W'(-w_s2) : WMAG_W'(w_s2);
			side_s3.zero <= (w_s2 == '0);
			side_s3.neg  <= nneg_s2 ^ {LANES{w_neg}};
			side_s3.hw   <= hw_sat;
			nmag_s3      <= nmag_s2;

			for (int i = 0; i < LANES; i++) begin
				div_s4.ovf[i] <= (WMAG_W'(nmag_s3[i]) >= wmag_s3);
				div_s4.rem[i] <= WMAG_W'(nmag_s3[i]);
			end
			div_s4.dvs  <= wmag_s3;
			div_s4.side <= side_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data  = div_s4;

	a_zero_w_hw: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && side_s3.zero |-> side_s3.hw == '0)
		else $error("zero W with nonzero homog_w");

endmodule

// ----- hdl/drp_div.sv -----
// Restoring divider, three lanes sharing one divisor, one quotient bit per stage.
module drp_div import drp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         in_valid,
	input  drp_div_in_t  in_data,
	output logic         out_valid,
	output drp_div_out_t out_data
);

	logic [DIV_STEPS:1]                           v_s;
	logic [LANES-1:0][WMAG_W-1:0]                 rem_s [1:DIV_STEPS];
	logic [LANES-1:0][Q_W-1:0]                    q_s   [1:DIV_STEPS];
	logic [WMAG_W-1:0]                            dvs_s [1:DIV_STEPS];
	logic [LANES-1:0]                             ovf_s [1:DIV_STEPS];
	drp_side_t                                    side_s[1:DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic                         v_in;
		logic [LANES-1:0][WMAG_W-1:0] rem_in;
		logic [LANES-1:0][Q_W-1:0]    q_in;
		logic [WMAG_W-1:0]            dvs_in;
		logic [LANES-1:0]             ovf_in;
		drp_side_t                    side_in;
		logic [LANES-1:0][WMAG_W:0]   r2;
		logic [LANES-1:0]             ge;
		logic [LANES-1:0][WMAG_W-1:0] rem_nx;

		if (k == 0) begin : g_head
			assign v_in    = in_valid;
			assign rem_in  = in_data.rem;
			assign q_in    = '0;
			assign dvs_in  = in_data.dvs;
			assign ovf_in  = in_data.ovf;
			assign side_in = in_data.side;
		end else begin : g_link
			assign v_in    = v_s[k];
			assign rem_in  = rem_s[k];
			assign q_in    = q_s[k];
			assign dvs_in  = dvs_s[k];
			assign ovf_in  = ovf_s[k];
			assign side_in = side_s[k];
		end

		always_comb begin
			for (int i = 0; i < LANES; i++) begin
				r2[i]     = {rem_in[i], 1'b0};
				ge[i]     = (r2[i] >= {1'b0, dvs_in});
				rem_nx[i] = ge[i] ? WMAG_W'(r2[i] - {1'b0, dvs_in}) : r2[i][WMAG_W-1:0];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else if (en) begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= rem_nx;
				for (int i = 0; i < LANES; i++) begin
					q_s[k+1][i] <= {q_in[i][Q_W-2:0], ge[i]};
				end
				dvs_s[k+1]  <= dvs_in;
				ovf_s[k+1]  <= ovf_in;
				side_s[k+1] <= side_in;
			end
		end
	end

	assign out_valid     = v_s[DIV_STEPS];
	assign out_data.ovf  = ovf_s[DIV_STEPS];
	assign out_data.mag  = q_s[DIV_STEPS];
	assign out_data.side = side_s[DIV_STEPS];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(v_s))
		else $error("divider valids moved during stall");

endmodule

// ----- hdl/drp_back.sv -----
// Output stage: sign, saturation, depth window and zero-W handling.
module drp_back import drp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  drp_div_out_t       in_data,
	input  logic [ZLIM_W-1:0]  z_min,
	input  logic [ZLIM_W-1:0]  z_max,
	output logic               out_valid,
	output logic [Q_W-1:0]     point_x,
	output logic [Q_W-1:0]     point_y,
	output logic [Q_W-1:0]     point_z,
	output logic [Q_W-1:0]     homog_w,
	output logic               keep
);

	function automatic logic [Q_W-1:0] sat_q(input logic [Q_W-1:0] mag,
		input logic neg, input logic ovf);
		logic [Q_W-1:0] r;
		if (ovf) begin
			r = neg ? Q_MIN : Q_MAX;
		end else if (neg) begin
			r = (mag > Q_MIN) ? Q_MIN : -mag;
		end else begin
			r = mag[Q_W-1] ? Q_MAX : mag;
		end
		return r;
	endfunction

	logic v_s37, zero_s37;
	logic [LANES-1:0][Q_W-1:0] pt_s37;
	logic [Q_W-1:0] hw_s37;
	logic keep_s37;

	logic [Q_W-1:0] zmag;
	logic keep_nx;
	assign zmag = in_data.mag[LANE_Z];

	always_comb begin
		if (in_data.side.zero || in_data.ovf[LANE_Z]) begin
			keep_nx = 1'b0;
		end else if (in_data.side.neg[LANE_Z]) begin
			// negative depth only passes as an exact zero
			keep_nx = (zmag == '0) && (z_min == '0) && (z_max != '0);
		end else begin
			keep_nx = (zmag >= Q_W'(z_min)) && (zmag < Q_W'(z_max));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s37 <= 1'b0;
		end else if (en) begin
			v_s37 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < LANES; i++) begin
				pt_s37[i] <= in_data.side.zero ? '0 :
					sat_q(in_data.mag[i], in_data.side.neg[i], in_data.ovf[i]);
			end
			hw_s37   <= in_data.side.hw;
			zero_s37 <= in_data.side.zero;
			keep_s37 <= keep_nx;
		end
	end

	assign out_valid = v_s37;
	assign point_x   = pt_s37[LANE_X];
	assign point_y   = pt_s37[LANE_Y];
	assign point_z   = pt_s37[LANE_Z];
	assign homog_w   = hw_s37;
	assign keep      = keep_s37;

	a_zero_drop: assert property (@(posedge clk) disable iff (!arst_n)
		v_s37 && zero_s37 |-> !keep_s37 && pt_s37[LANE_Z] == '0)
		else $error("zero W point not dropped");

endmodule
